FILE: rtl/assert_macros.svh
// assertion helpers for the element-wise combiner
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/ewc_pkg.sv
// ----------------------------------------------------------------------------
// ewc_pkg
// shared constants and types of the element-wise combiner
// ----------------------------------------------------------------------------
`default_nettype none
package ewc_pkg;
   localparam int MAX_INPUTS_DEF = 4;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int NUM_X          = 4;
   localparam int XW             = 32;

   localparam logic [1:0] OP_PROD = 2'd0;
   localparam logic [1:0] OP_SUM  = 2'd1;
   localparam logic [1:0] OP_MAX  = 2'd2;

   localparam logic [2:0] REG_OPERATION = 3'd0;
   localparam logic [2:0] REG_NUM_IN    = 3'd1;
   localparam logic [2:0] REG_MASK      = 3'd2;
   localparam logic [2:0] REG_COEFF0    = 3'd3;
   localparam logic [2:0] REG_COEFF3    = 3'd6;

   // per-item context handed from cell to cell
   typedef struct packed {
      logic       func;
      logic [1:0] op;
      logic [2:0] n;
      logic [3:0] mask;
      logic [1:0] win_in;
   } ctl_type;
endpackage
`default_nettype wire

FILE: rtl/ewc_qmul.sv
// ----------------------------------------------------------------------------
// ewc_qmul
// registered fixed-point multiply: round to nearest, saturate
// ----------------------------------------------------------------------------
`default_nettype none
module ewc_qmul #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         enable,
   input  wire logic signed [DATA_WIDTH-1:0] a,
   input  wire logic signed [DATA_WIDTH-1:0] b,
   output logic signed [DATA_WIDTH-1:0]      q,
   output logic                              sat
);
   localparam int PW = 2 * DATA_WIDTH + 1;
   localparam logic signed [DATA_WIDTH-1:0] HI = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] LO = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic signed [PW-1:0] prod, rnd, shf;
   logic signed [DATA_WIDTH-1:0] q_in;
   logic sat_in;

   // exact product, round bias, floor shift, clip
   always_comb begin
      prod = PW'(a) * PW'(b);
      rnd  = (FRAC_BITS > 0) ? prod + (PW'(1) <<< (FRAC_BITS > 0 ? FRAC_BITS - 1 : 0))
                             : prod;
      shf  = rnd >>> FRAC_BITS;
      sat_in = 1'b0;
      if (shf > PW'(HI)) begin
         q_in = HI; sat_in = 1'b1;
      end else if (shf < PW'(LO)) begin
         q_in = LO; sat_in = 1'b1;
      end else begin
         q_in = shf[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         q   <= q_in;
         sat <= sat_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/ewc_cell.sv
// ----------------------------------------------------------------------------
// ewc_cell
// one stage of the combine chain: folds one scaled term into the running
// forward value and, in product backward, into each other gradient lane
// ----------------------------------------------------------------------------
`default_nettype none
module ewc_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   parameter int IDX        = 0
) (
   input  wire logic                         clock,
   input  wire logic                         enable,
   // term of this cell, already scaled, with its own flag
   input  wire logic signed [DATA_WIDTH-1:0] t,
   input  wire logic                         t_sat,
   input  wire ewc_pkg::ctl_type             ctl,
   input  wire logic signed [DATA_WIDTH+2:0] acc_i,
   input  wire logic [1:0]                   win_i,
   input  wire logic [ewc_pkg::NUM_X-1:0][DATA_WIDTH-1:0] g_i,
   input  wire logic                         sat_i,
   output logic signed [DATA_WIDTH+2:0]      acc_o,
   output logic [1:0]                        win_o,
   output logic [ewc_pkg::NUM_X-1:0][DATA_WIDTH-1:0] g_o,
   output logic                              sat_o
);
   import ewc_pkg::*;

   localparam int AW = DATA_WIDTH + 3;
   localparam logic [1:0] MY = 2'(IDX);

   logic active;
   logic t_used;
   logic [NUM_X-1:0] mq_sat;
   logic [NUM_X:0][DATA_WIDTH-1:0] mq;
   logic [NUM_X:0] mq_s;
   logic signed [AW-1:0] acc_d;
   logic [1:0] win_d;
   logic [NUM_X-1:0][DATA_WIDTH-1:0] g_d;
   logic [NUM_X-1:0] g_use;
   logic pass_d, sat_d, prod_fwd;
   ctl_type ctl_d;
   logic signed [DATA_WIDTH-1:0] t_d;

   assign active = (ctl.n > 3'(IDX));
   assign prod_fwd = !ctl.func && ctl.op == OP_PROD && IDX != 0;

   // the top multiplier lane carries the forward product, lanes 0..3 the gradients
   ewc_qmul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mf (
      .clock(clock), .enable(enable), .a(acc_i[DATA_WIDTH-1:0]), .b(t),
      .q(mq[NUM_X]), .sat(mq_s[NUM_X]));

   for (genvar k = 0; k < NUM_X; k++) begin : g_lane
      ewc_qmul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mg (
         .clock(clock), .enable(enable), .a(g_i[k]), .b(t),
         .q(mq[k]), .sat(mq_s[k]));
      // product backward multiplies lane k by this term when k differs
      assign g_use[k] = ctl.func && ctl.op == OP_PROD && active && (k != IDX)
                        && ctl.mask[k] && (ctl.n > 3'(k));
   end
   assign mq_sat = mq_s[NUM_X-1:0];

   // the term counts toward the flag only when some path really uses it
   assign t_used = active && (!ctl.func || (|g_use));

   // register the non-multiply paths alongside the multipliers
   always_ff @(posedge clock) begin
      if (enable) begin
         ctl_d  <= ctl;
         t_d    <= t;
         pass_d <= active;
         win_d  <= win_i;
         sat_d  <= sat_i | (t_used & t_sat);
         g_d    <= g_i;
         acc_d  <= acc_i;
      end
   end

   logic [NUM_X-1:0] g_use_d;
   logic prod_fwd_d;
   always_ff @(posedge clock) begin
      if (enable) begin
         g_use_d    <= g_use;
         prod_fwd_d <= prod_fwd && active;
      end
   end

   // fold this term in after the multiply stage
   always_comb begin
      acc_o = acc_d;
      win_o = win_d;
      sat_o = sat_d;
      g_o   = g_d;
      if (!ctl_d.func && pass_d) begin
         if (ctl_d.op == OP_PROD) begin
            if (IDX == 0) acc_o = AW'(t_d);
            else if (prod_fwd_d) begin
               acc_o = AW'($signed(mq[NUM_X]));
               sat_o = sat_d | mq_s[NUM_X];
            end
         end else if (ctl_d.op == OP_MAX) begin
            if (IDX == 0 || AW'(t_d) > acc_d) begin
               acc_o = AW'(t_d);
               win_o = MY;
            end
         end else begin
            acc_o = acc_d + AW'(t_d);
         end
      end
      for (int k = 0; k < NUM_X; k++) begin
         if (g_use_d[k]) begin
            g_o[k] = mq[k];
            sat_o  = sat_o | mq_sat[k];
         end
      end
   end
endmodule
`default_nettype wire

FILE: rtl/eltwise_combine_fwd_bwd.sv
// ----------------------------------------------------------------------------
// eltwise_combine_fwd_bwd
// element-wise product / sum / maximum of up to four scaled inputs, with
// backward gradients, in saturating signed fixed point
// ----------------------------------------------------------------------------
// One beat in, one beat out, one beat per cycle sustained. An item goes
// through a scale stage (all four x*coeff and dy*coeff multiplies in
// parallel) and then a chain of four cells, each one register stage deep
// (one multiply rank, fold after it), then the output register that presents
// the result. The pipeline stalls as a whole only when the output register
// is full and not taken, so a finished result never blocks a new beat
// otherwise.
`default_nettype none
module eltwise_combine_fwd_bwd #(
   parameter int MAX_INPUTS = ewc_pkg::MAX_INPUTS_DEF,
   parameter int FRAC_BITS  = ewc_pkg::FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_func,
   input  wire logic signed [31:0]   req_x0,
   input  wire logic signed [31:0]   req_x1,
   input  wire logic signed [31:0]   req_x2,
   input  wire logic signed [31:0]   req_x3,
   input  wire logic signed [31:0]   req_dy,
   input  wire logic [1:0]           req_winner_in,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic signed [31:0]        rsp_y,
   output logic [1:0]                rsp_winner,
   output logic signed [31:0]        rsp_dx0,
   output logic signed [31:0]        rsp_dx1,
   output logic signed [31:0]        rsp_dx2,
   output logic signed [31:0]        rsp_dx3,
   output logic                      rsp_saturated,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [2:0]           csr_index,
   input  wire logic [31:0]          csr_data
);
   import ewc_pkg::*;
   `include "assert_macros.svh"

   localparam int DW  = DATA_WIDTH_DEF;
   localparam int AW  = DW + 3;
   localparam int LAT = 1 + NUM_X;
   localparam logic [2:0] NMAX = 3'((MAX_INPUTS < NUM_X) ? MAX_INPUTS : NUM_X);
   localparam logic signed [AW-1:0] HI = AW'({1'b0, {(DW-1){1'b1}}});
   localparam logic signed [AW-1:0] LO = -HI - AW'(1);

   // configuration registers
   logic [1:0] op_ff;
   logic [2:0] n_ff;
   logic [3:0] mask_ff;
   logic signed [NUM_X-1:0][DW-1:0] coeff_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff   <= OP_SUM;
         n_ff    <= 3'd2;
         mask_ff <= 4'hf;
         for (int j = 0; j < NUM_X; j++) coeff_ff[j] <= DW'(65536);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_OPERATION: op_ff   <= csr_data[1:0];
            REG_NUM_IN:    n_ff    <= csr_data[2:0];
            REG_MASK:      mask_ff <= csr_data[3:0];
            default: if (csr_index >= REG_COEFF0 && csr_index <= REG_COEFF3)
               coeff_ff[2'(csr_index - REG_COEFF0)] <= csr_data;
         endcase
      end
   end

   // pipeline control: every stage advances together unless output is held
   logic [LAT-1:0] vld_ff;
   logic out_valid_ff;
   logic adv, accept;
   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[LAT-2:0], accept};
         out_valid_ff <= vld_ff[LAT-1];
      end
   end
   assign rsp_valid = out_valid_ff;

   // effective input count and operation
   ctl_type ctl0;
   always_comb begin
      ctl0.func   = req_func;
      ctl0.op     = (op_ff == 2'd3) ? OP_SUM : op_ff;
      ctl0.n      = (n_ff == 3'd0) ? 3'd1 : ((n_ff > NMAX) ? NMAX : n_ff);
      ctl0.mask   = mask_ff;
      ctl0.win_in = req_winner_in;
   end

   // scale stage: x_j*coeff_j and dy*coeff_j
   logic [NUM_X-1:0][DW-1:0] xin, t, gs;
   logic [NUM_X-1:0] t_s, gs_s;
   ctl_type ctl1;
   assign xin = {req_x3, req_x2, req_x1, req_x0};
   for (genvar j = 0; j < NUM_X; j++) begin : g_scale
      ewc_qmul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_tx (
         .clock(clock), .enable(adv), .a(xin[j]), .b(coeff_ff[j]),
         .q(t[j]), .sat(t_s[j]));
      ewc_qmul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_tg (
         .clock(clock), .enable(adv), .a(req_dy), .b(coeff_ff[j]),
         .q(gs[j]), .sat(gs_s[j]));
   end
   always_ff @(posedge clock) if (adv) ctl1 <= ctl0;

   // seed gradient lanes
   logic [NUM_X-1:0][DW-1:0] g0;
   logic sat0;
   always_comb begin
      sat0 = 1'b0;
      for (int j = 0; j < NUM_X; j++) begin
         g0[j] = '0;
         if (ctl1.func) begin
            if (ctl1.op == OP_MAX) begin
               if (ctl1.win_in == 2'(j) && 3'(j) < ctl1.n && ctl1.mask[j]) begin
                  g0[j] = gs[j]; sat0 = sat0 | gs_s[j];
               end
            end else if (3'(j) < ctl1.n && ctl1.mask[j]) begin
               g0[j] = gs[j]; sat0 = sat0 | gs_s[j];
            end
         end
      end
   end

   // chain of cells; context and terms delayed to line up with each cell
   logic signed [NUM_X:0][AW-1:0] acc;
   logic [NUM_X:0][1:0] win;
   logic [NUM_X:0][NUM_X-1:0][DW-1:0] g;
   logic [NUM_X:0] sat;
   ctl_type [NUM_X:0] ctl_c;
   logic [NUM_X:0][NUM_X-1:0][DW-1:0] t_c;
   logic [NUM_X:0][NUM_X-1:0] ts_c;

   assign acc[0]   = '0;
   assign win[0]   = '0;
   assign g[0]     = g0;
   assign sat[0]   = sat0;
   assign ctl_c[0] = ctl1;
   assign t_c[0]   = t;
   assign ts_c[0]  = t_s;

   for (genvar c = 0; c < NUM_X; c++) begin : g_cell
      ctl_type ctl_mid_ff;
      logic [NUM_X-1:0][DW-1:0] t_mid_ff;
      logic [NUM_X-1:0] ts_mid_ff;
      ewc_cell #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS), .IDX(c)) u_cell (
         .clock(clock), .enable(adv), .t(t_c[c][c]), .t_sat(ts_c[c][c]),
         .ctl(ctl_c[c]), .acc_i(acc[c]), .win_i(win[c]), .g_i(g[c]),
         .sat_i(sat[c]), .acc_o(acc[c+1]), .win_o(win[c+1]), .g_o(g[c+1]),
         .sat_o(sat[c+1]));
      // cell outputs are combinational after one internal rank: add a rank
      always_ff @(posedge clock) begin
         if (adv) begin
            ctl_mid_ff <= ctl_c[c];
            t_mid_ff   <= t_c[c];
            ts_mid_ff  <= ts_c[c];
         end
      end
      assign ctl_c[c+1] = ctl_mid_ff;
      assign t_c[c+1]   = t_mid_ff;
      assign ts_c[c+1]  = ts_mid_ff;
   end

   // final saturation and output register
   logic signed [AW-1:0] accf;
   logic [DW-1:0] y_in;
   logic sat_in;
   ctl_type ctlf;
   assign accf = acc[NUM_X];
   assign ctlf = ctl_c[NUM_X];
   always_comb begin
      y_in   = accf[DW-1:0];
      sat_in = sat[NUM_X];
      if (ctlf.func) y_in = '0;
      else if (ctlf.op == OP_SUM) begin
         if (accf > HI) begin y_in = HI[DW-1:0]; sat_in = 1'b1; end
         else if (accf < LO) begin y_in = LO[DW-1:0]; sat_in = 1'b1; end
      end
   end

   logic [DW-1:0] y_ff;
   logic [1:0] win_ff;
   logic [NUM_X-1:0][DW-1:0] dx_ff;
   logic sat_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         y_ff   <= y_in;
         win_ff <= (!ctlf.func && ctlf.op == OP_MAX) ? win[NUM_X] : 2'd0;
         dx_ff  <= ctlf.func ? g[NUM_X] : '0;
         sat_ff <= sat_in;
      end
   end
   assign rsp_y         = y_ff;
   assign rsp_winner    = win_ff;
   assign rsp_dx0       = dx_ff[0];
   assign rsp_dx1       = dx_ff[1];
   assign rsp_dx2       = dx_ff[2];
   assign rsp_dx3       = dx_ff[3];
   assign rsp_saturated = sat_ff;

   // a held result stays while not taken
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // no new beat taken while output is stalled
   `ASSERT_IMPL(a_stall, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   // beats with a nonzero winner report no gradient on dx0 and dx1
   `ASSERT_IMPL(a_fwd, clock, reset, rsp_valid && rsp_winner != 2'd0,
                rsp_dx0 == '0 && rsp_dx1 == '0)
endmodule
`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// element-wise combiner testbench
// Drives directed and random beats through the combiner under several register
// settings, predicts each forward and backward result in saturating Q16.16,
// and checks every result beat field by field under random gaps and stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
   import ewc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic             func;
      logic [3:0][31:0] x;
      logic [31:0]      dy;
      logic [1:0]       win;
   } elem_beat_type;

   typedef struct packed {
      logic [31:0]      y;
      logic [1:0]       winner;
      logic [3:0][31:0] dx;
      logic             sat;
   } grad_beat_type;

   logic clock, reset;
   logic req_valid, req_ready, req_func;
   logic signed [31:0] req_x0, req_x1, req_x2, req_x3, req_dy;
   logic [1:0] req_winner_in;
   logic rsp_valid, rsp_ready;
   logic signed [31:0] rsp_y, rsp_dx0, rsp_dx1, rsp_dx2, rsp_dx3;
   logic [1:0] rsp_winner;
   logic rsp_saturated;
   logic csr_valid, csr_ready;
   logic [2:0] csr_index;
   logic [31:0] csr_data;

   // register shadow used for prediction
   logic [1:0]  cur_op;
   logic [2:0]  cur_num;
   logic [3:0]  cur_mask;
   logic signed [31:0] cur_coeff [4];

   elem_beat_type pending_beats [$];
   grad_beat_type expected_grads [$];
   int mismatches;
   int cycles;
   int tx_gap, rx_stall;
   bit tx_no_gaps, rx_no_stalls, rx_hold, rx_hold_go;

   eltwise_combine_fwd_bwd dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // saturating Q16.16 helpers
   function automatic longint clip32(longint v, inout bit s);
      if (v > 64'sd2147483647) begin
         s = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         s = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint fx_mul(longint a, longint b, inout bit s);
      longint p;
      p = a * b + 64'sd32768;
      return clip32(p >>> 16, s);
   endfunction

   function automatic grad_beat_type combine_elem(elem_beat_type b);
      grad_beat_type r;
      longint t [4];
      longint acc, g;
      bit s;
      int n, w;
      r = '0;
      s = 1'b0;
      n = cur_num;
      if (n < 1) n = 1;
      if (n > 4) n = 4;
      if (!b.func) begin
         if (cur_op == OP_PROD) begin
            acc = fx_mul(longint'(signed'(b.x[0])), cur_coeff[0], s);
            for (int j = 1; j < n; j++)
               acc = fx_mul(acc, fx_mul(longint'(signed'(b.x[j])), cur_coeff[j], s), s);
         end else if (cur_op == OP_MAX) begin
            acc = fx_mul(longint'(signed'(b.x[0])), cur_coeff[0], s);
            for (int j = 1; j < n; j++) begin
               t[j] = fx_mul(longint'(signed'(b.x[j])), cur_coeff[j], s);
               if (t[j] > acc) begin
                  acc = t[j];
                  r.winner = j[1:0];
               end
            end
         end else begin
            acc = 0;
            for (int j = 0; j < n; j++)
               acc += fx_mul(longint'(signed'(b.x[j])), cur_coeff[j], s);
            acc = clip32(acc, s);
         end
         r.y = acc[31:0];
      end else if (cur_op == OP_MAX) begin
         w = b.win;
         if (w < n && cur_mask[w])
            r.dx[w] = 32'(fx_mul(longint'(signed'(b.dy)), cur_coeff[w], s));
      end else begin
         for (int j = 0; j < n; j++) begin
            if (cur_mask[j]) begin
               g = fx_mul(longint'(signed'(b.dy)), cur_coeff[j], s);
               if (cur_op == OP_PROD)
                  for (int k = 0; k < n; k++)
                     if (k != j)
                        g = fx_mul(g, fx_mul(longint'(signed'(b.x[k])), cur_coeff[k], s), s);
               r.dx[j] = g[31:0];
            end
         end
      end
      r.sat = s;
      return r;
   endfunction

   // sender: one beat at a time with a random gap after each
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_grads.push_back(combine_elem({req_func, req_x3, req_x2, req_x1,
                                                   req_x0, req_dy, req_winner_in}));
         if (req_valid && !req_ready) begin
            // hold the beat
         end else if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            req_valid <= 1'b1;
            req_func <= pending_beats[0].func;
            req_x0 <= pending_beats[0].x[0];
            req_x1 <= pending_beats[0].x[1];
            req_x2 <= pending_beats[0].x[2];
            req_x3 <= pending_beats[0].x[3];
            req_dy <= pending_beats[0].dy;
            req_winner_in <= pending_beats[0].win;
            void'(pending_beats.pop_front());
            tx_gap <= tx_no_gaps ? 0 : $urandom_range(0, 5);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      grad_beat_type got, want;
      int nxt_stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_y, rsp_winner, rsp_dx3, rsp_dx2, rsp_dx1, rsp_dx0, rsp_saturated};
            if (expected_grads.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result beat with nothing expected: %h", got);
            end else begin
               want = expected_grads.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch y %h/%h win %0d/%0d dx %h/%h sat %b/%b",
                              want.y, got.y, want.winner, got.winner,
                              want.dx, got.dx, want.sat, got.sat);
               end
            end
            nxt_stall = rx_no_stalls ? 0 : $urandom_range(0, 5);
            rx_stall <= nxt_stall;
            rsp_ready <= (nxt_stall == 0) && !rx_hold;
         end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !rx_hold;
         end
      end
   end

   // long receiver hold-off so the pipeline backs up into the input
   initial begin
      rx_hold = 1'b0;
      wait (rx_hold_go);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("** eltwise_combine_fwd_bwd: FAILED **");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_OPERATION: cur_op = value[1:0];
         REG_NUM_IN:    cur_num = value[2:0];
         REG_MASK:      cur_mask = value[3:0];
         default:       if (idx >= REG_COEFF0 && idx <= REG_COEFF3)
                           cur_coeff[2'(idx - REG_COEFF0)] = value;
      endcase
   endtask

   task automatic set_config(logic [1:0] op, logic [2:0] n, logic [3:0] mask,
                             logic [31:0] c0, logic [31:0] c1,
                             logic [31:0] c2, logic [31:0] c3);
      write_reg(REG_OPERATION, {30'd0, op});
      write_reg(REG_NUM_IN, {29'd0, n});
      write_reg(REG_MASK, {28'd0, mask});
      write_reg(REG_COEFF0, c0);
      write_reg(REG_COEFF0 + 3'd1, c1);
      write_reg(REG_COEFF0 + 3'd2, c2);
      write_reg(REG_COEFF3, c3);
   endtask

   // wait until every beat is sent and every result has come back
   task automatic drain();
      while (pending_beats.size() > 0 || req_valid || expected_grads.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_q(bit gentle);
      case ($urandom_range(0, gentle ? 5 : 7))
         0:       return 32'h0001_0000;
         1, 2:    return $urandom_range(0, 32'h3FFFF);
         3, 4:    return -$urandom_range(0, 32'h3FFFF);
         5:       return $urandom_range(0, 32'hFFF);
         6:       return $urandom();
         default: case ($urandom_range(0, 2))
                     0: return 32'h7FFF_FFFF;
                     1: return 32'h8000_0000;
                     default: return 32'h0;
                  endcase
      endcase
   endfunction

   task automatic queue_beat(bit func, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                             logic [31:0] d, logic [31:0] dy, logic [1:0] w);
      elem_beat_type e;
      e.func = func;
      e.x = {d, c, b, a};
      e.dy = dy;
      e.win = w;
      pending_beats.push_back(e);
   endtask

   task automatic queue_random(int count);
      logic [31:0] tie;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 5) == 0) begin
            tie = rand_q(1);
            queue_beat(1'($urandom_range(0, 1)), tie, tie, tie, tie, rand_q(1),
                       2'($urandom_range(0, 3)));
         end else begin
            queue_beat(1'($urandom_range(0, 1)), rand_q(1), rand_q(1), rand_q(1),
                       rand_q(1), rand_q(0), 2'($urandom_range(0, 3)));
         end
      end
   endtask

   initial begin
      mismatches = 0;
      cycles = 0;
      tx_no_gaps = 1'b0;
      rx_no_stalls = 1'b0;
      rx_hold_go = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = 1'b0;
      req_x0 = '0; req_x1 = '0; req_x2 = '0; req_x3 = '0;
      req_dy = '0;
      req_winner_in = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cur_op = OP_SUM;
      cur_num = 3'd2;
      cur_mask = 4'hF;
      for (int j = 0; j < 4; j++) cur_coeff[j] = 32'h0001_0000;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, extremes of the data fields
      queue_beat(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0);
      queue_beat(0, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
      queue_beat(1, 0, 0, 0, 0, 32'h8000_0000, 3);
      queue_beat(1, 0, 0, 0, 0, 32'h7FFF_FFFF, 1);
      drain();
      // product over four inputs with saturating chain
      set_config(OP_PROD, 3'd4, 4'hF, 32'h0001_0000, 32'h0002_0000,
                 32'hFFFF_8000, 32'h7FFF_FFFF);
      queue_beat(0, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_0001, 0, 0);
      queue_beat(1, 32'h0003_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h0100_0000,
                 32'h0001_0000, 0);
      queue_beat(0, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_8000, 32'h0001_0000, 0, 2);
      drain();
      // maximum with a tie, winner at or above inputs in use
      set_config(OP_MAX, 3'd3, 4'hB, 32'h0001_0000, 32'h0001_0000,
                 32'h0001_0000, 32'h8000_0000);
      queue_beat(0, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h0009_0000, 0, 0);
      queue_beat(0, 32'h8000_0000, 32'hFFFF_0000, 32'h0001_0000, 0, 0, 0);
      queue_beat(1, 0, 0, 0, 0, 32'h0002_0000, 3);
      queue_beat(1, 0, 0, 0, 0, 32'h0002_0000, 1);
      queue_beat(1, 0, 0, 0, 0, 32'h0002_0000, 2);
      drain();
      // operation code 3 with inputs in use zero
      set_config(2'd3, 3'd0, 4'h1, 32'h8000_0000, 0, 0, 0);
      queue_beat(0, 32'h8000_0000, 32'h1234_5678, 0, 0, 0, 0);
      queue_beat(1, 0, 0, 0, 0, 32'hFFFF_0000, 0);
      drain();
      // inputs in use above four, sum with clipping
      set_config(OP_SUM, 3'd7, 4'h6, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_beat(0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0);
      queue_beat(1, 0, 0, 0, 0, 32'h0001_0000, 0);
      queue_beat(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
      drain();

      // random phases, each under its own register setting
      for (int p = 0; p < 15; p++) begin
         set_config(2'($urandom_range(0, 3)),
                    ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(1, 4)),
                    4'($urandom_range(0, 15)), rand_q(0), rand_q(0), rand_q(0), rand_q(0));
         tx_no_gaps = (p % 4 == 1);
         rx_no_stalls = (p % 4 == 1) || (p % 5 == 3);
         if (p == 6) begin
            tx_no_gaps = 1'b1;
            rx_hold_go = 1'b1;
         end
         queue_random(38);
         drain();
      end

      if (mismatches == 0)
         $display("** eltwise_combine_fwd_bwd: PASSED **");
      else
         $display("** eltwise_combine_fwd_bwd: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
